// ===== rtl/mte_pkg.sv =====
// Package: types, constants and the MFM cell function of the MFM track encoder.
package mte_pkg;

  localparam logic [15:0] INDEX_WORD = 16'h5224;
  localparam logic [15:0] SYNC_WORD  = 16'h4489;
  localparam logic [7:0]  INDEX_BYTE = 8'hC2;
  localparam logic [7:0]  SYNC_BYTE  = 8'hA1;
  localparam logic [7:0]  ID_MARK    = 8'hFE;
  localparam logic [7:0]  DATA_MARK  = 8'hFB;

  localparam int unsigned BASE_SECTOR = 128;
  localparam int unsigned ID_LENGTH   = 7;
  localparam int unsigned MAX_WORDS   = 3;

  localparam int unsigned COPY_W  = 11;
  localparam int unsigned IDPOS_W = 3;

  localparam logic [IDPOS_W-1:0] ID_SIZE_POS = 3'd4;
  localparam logic [IDPOS_W-1:0] ID_LAST_POS = IDPOS_W'(ID_LENGTH - 1);

  // Words caused by one item, first word in slot 0
  typedef struct packed {
    logic [MAX_WORDS-1:0][15:0] words;
    logic [1:0]                 count;
    logic                       last;
  } mte_bundle_t;

  // Clock cell is 1 only when the preceding data cell and this data bit are both 0
  function automatic logic [15:0] mfm_encode(input logic prev, input logic [7:0] b);
    logic [15:0] w;
    logic        before_bit;
    w          = '0;
    before_bit = prev;
    for (int i = 7; i >= 0; i--) begin
      w[2*i+1]   = ~before_bit & ~b[i];
      w[2*i]     = b[i];
      before_bit = b[i];
    end
    return w;
  endfunction

endpackage

// ===== rtl/mte_if.sv =====
// Stream interfaces for track bytes in and MFM cell words out.
interface mte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       end_of_track;

  modport source (output valid, output track_byte, output end_of_track, input ready);
  modport sink   (input valid, input track_byte, input end_of_track, output ready);
endinterface

interface mte_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_word;
  logic        run_end;
  logic        track_end;

  modport source (output valid, output cell_word, output run_end, output track_end,
                  input ready);
  modport sink   (input valid, input cell_word, input run_end, input track_end,
                  output ready);
endinterface

// ===== rtl/mfm_track_encoder_with_marks.sv =====
// Top level of the MFM track encoder with index and sync mark recognition.
//
//  channel | dir | payload                            | item
//  in_i    | in  | track_byte[7:0], end_of_track      | one raw track byte
//  out_o   | out | cell_word[15:0], run_end, track_end | one 16-cell MFM word
//
//  An item passes an input register, then the encoder logic loads its 0 to 3 words
//  into the result register, which offers them to the sink.
//  One item per cycle while the sink is ready and each gives at most one word;
//  a mark burst or track-end flush holds the result register until it drains.
//  The input register takes one more item while a result waits on a stalled sink.
//  Reset clears all encoder state at once; no clearing pass.
module mfm_track_encoder_with_marks (
  input  logic     clk_i,
  input  logic     rst_ni,
  mte_in_if.sink   in_i,
  mte_out_if.source out_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       can_load;
  logic       advance;

  mte_pkg::mte_bundle_t bundle;

  assign advance    = in_vld_q && can_load;
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.track_byte;
      in_last_q <= in_i.end_of_track;
    end
  end

  mte_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .track_byte_i   (in_byte_q),
    .end_of_track_i (in_last_q),
    .bundle_o       (bundle)
  );

  // Items that cause no word leave the result register untouched
  mte_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && (bundle.count != 2'd0)),
    .bundle_i   (bundle),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// ===== rtl/mte_core.sv =====
// Encoder state and the per-item mark detection, copy tracking and MFM encoding.
module mte_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          track_byte_i,
  input  logic                end_of_track_i,
  output mte_pkg::mte_bundle_t bundle_o
);

  logic [7:0]                   la0_q, la0_d, la1_q, la1_d;
  logic [1:0]                   fill_q, fill_d;
  logic [mte_pkg::COPY_W-1:0]   copy_q, copy_d;
  logic [mte_pkg::IDPOS_W-1:0]  idpos_q, idpos_d;
  logic [1:0]                   size_q, size_d;
  logic                         prev_q, prev_d;
  logic                         wait_q, wait_d;

  logic        prev_m;
  logic [1:0]  n_main, n_flush;
  logic [15:0] main_w, mark_w, f0, f1;
  logic        flush_en;

  always_comb begin
    la0_d   = la0_q;
    la1_d   = la1_q;
    fill_d  = fill_q;
    copy_d  = copy_q;
    idpos_d = idpos_q;
    size_d  = size_q;
    wait_d  = wait_q;
    prev_m  = prev_q;
    n_main  = 2'd0;
    main_w  = mte_pkg::mfm_encode(prev_q, track_byte_i);
    mark_w  = mte_pkg::INDEX_WORD;

    if (copy_q != '0) begin
      n_main = 2'd1;
      prev_m = track_byte_i[0];
      if (idpos_q == mte_pkg::ID_SIZE_POS) size_d = track_byte_i[1:0];
      if (idpos_q != '0) begin
        idpos_d = (idpos_q == mte_pkg::ID_LAST_POS) ? '0 : idpos_q + 1'b1;
      end
      copy_d = copy_q - 1'b1;
    end else if (wait_q) begin
      wait_d = 1'b0;
      if (track_byte_i == mte_pkg::ID_MARK) begin
        n_main  = 2'd1;
        prev_m  = track_byte_i[0];
        copy_d  = mte_pkg::COPY_W'(mte_pkg::ID_LENGTH - 1);
        idpos_d = mte_pkg::IDPOS_W'(1);
      end else if (track_byte_i == mte_pkg::DATA_MARK) begin
        n_main  = 2'd1;
        prev_m  = track_byte_i[0];
        copy_d  = (mte_pkg::COPY_W'(mte_pkg::BASE_SECTOR) << size_q) + mte_pkg::COPY_W'(2);
        idpos_d = '0;
      end else begin
        la0_d  = track_byte_i;
        fill_d = 2'd1;
      end
    end else if (fill_q[1]) begin
      if (la0_q == mte_pkg::INDEX_BYTE && la1_q == mte_pkg::INDEX_BYTE &&
          track_byte_i == mte_pkg::INDEX_BYTE) begin
        n_main = 2'd3;
        mark_w = mte_pkg::INDEX_WORD;
        prev_m = mte_pkg::INDEX_WORD[0];
        fill_d = 2'd0;
      end else if (la0_q == mte_pkg::SYNC_BYTE && la1_q == mte_pkg::SYNC_BYTE &&
                   track_byte_i == mte_pkg::SYNC_BYTE) begin
        n_main = 2'd3;
        mark_w = mte_pkg::SYNC_WORD;
        prev_m = mte_pkg::SYNC_WORD[0];
        fill_d = 2'd0;
        wait_d = 1'b1;
      end else begin
        n_main = 2'd1;
        main_w = mte_pkg::mfm_encode(prev_q, la0_q);
        prev_m = la0_q[0];
        la0_d  = la1_q;
        la1_d  = track_byte_i;
      end
    end else if (fill_q == 2'd0) begin
      la0_d  = track_byte_i;
      fill_d = 2'd1;
    end else begin
      la1_d  = track_byte_i;
      fill_d = 2'd2;
    end

    // Track end: flush held bytes; no mark can form since zeros follow
    flush_en = end_of_track_i && (copy_d == '0) && !wait_d;
    n_flush  = flush_en ? fill_d : 2'd0;
    f0       = mte_pkg::mfm_encode(prev_m, la0_d);
    f1       = mte_pkg::mfm_encode(la0_d[0], la1_d);

    bundle_o.count = n_main + n_flush;
    bundle_o.last  = end_of_track_i;
    case (n_main)
      2'd3: begin
        bundle_o.words[0] = mark_w;
        bundle_o.words[1] = mark_w;
        bundle_o.words[2] = mark_w;
      end
      2'd1: begin
        bundle_o.words[0] = main_w;
        bundle_o.words[1] = f0;
        bundle_o.words[2] = f1;
      end
      default: begin
        bundle_o.words[0] = f0;
        bundle_o.words[1] = f1;
        bundle_o.words[2] = f1;
      end
    endcase

    prev_d = prev_m;
    if (end_of_track_i) begin
      la0_d   = '0;
      la1_d   = '0;
      fill_d  = '0;
      copy_d  = '0;
      idpos_d = '0;
      size_d  = '0;
      prev_d  = 1'b0;
      wait_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la0_q   <= '0;
      la1_q   <= '0;
      fill_q  <= '0;
      copy_q  <= '0;
      idpos_q <= '0;
      size_q  <= '0;
      prev_q  <= 1'b0;
      wait_q  <= 1'b0;
    end else if (advance_i) begin
      la0_q   <= la0_d;
      la1_q   <= la1_d;
      fill_q  <= fill_d;
      copy_q  <= copy_d;
      idpos_q <= idpos_d;
      size_q  <= size_d;
      prev_q  <= prev_d;
      wait_q  <= wait_d;
    end
  end

endmodule

// ===== rtl/mte_out_buf.sv =====
// Result register: holds the words of one item and hands them out one per cycle while the sink is ready.
module mte_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mte_pkg::mte_bundle_t bundle_i,
  output logic                 can_load_o,
  mte_out_if.source            out_o
);

  logic [1:0] cnt_q, cnt_d, pos_q, pos_d;
  logic [mte_pkg::MAX_WORDS-1:0][15:0] words_q;
  logic       last_q;
  logic       on_last;

  assign on_last    = (pos_q == cnt_q - 2'd1);
  assign can_load_o = (cnt_q == 2'd0) || (out_o.ready && on_last);

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (out_o.valid && out_o.ready) begin
      if (on_last) cnt_d = 2'd0;
      else         pos_d = pos_q + 2'd1;
    end
    if (load_i) begin
      cnt_d = bundle_i.count;
      pos_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      pos_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= bundle_i.words;
      last_q  <= bundle_i.last;
    end
  end

  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.cell_word = words_q[pos_q];
  assign out_o.run_end   = on_last;
  assign out_o.track_end = on_last && last_q;

endmodule

// ===== rtl/mte_checker.sv =====
// Port checker for the MFM track encoder, bound to the top level.
module mte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] cell_word_i,
  input logic        run_end_i,
  input logic        track_end_i
);

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_word_i))
    else $error("output word changed while stalled");

  // Every word, marks included, has no two adjacent 1 cells
  a_mfm_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((cell_word_i & (cell_word_i >> 1)) == 16'h0000))
    else $error("adjacent 1 cells in output word");

  a_track_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && track_end_i |-> run_end_i)
    else $error("track end without run end");

  // Words of one item follow without a gap
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_end_i |=> out_valid_i)
    else $error("gap inside the words of one item");

endmodule

bind mfm_track_encoder_with_marks mte_checker u_mte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cell_word_i (out_o.cell_word),
  .run_end_i   (out_o.run_end),
  .track_end_i (out_o.track_end)
);

// ===== dv/mte_tb_pkg.sv =====
// Word predictor and scoreboard for the MFM track encoder testbench.
package mte_tb_pkg;

  typedef struct packed {
    logic [15:0] cells;
    logic        run_end;
    logic        track_end;
  } cell_word_t;

  class mfm_word_scoreboard;
    cell_word_t                  expected_words[$];
    cell_word_t                  item_words[$];
    logic [7:0]                  held_bytes[2];
    logic [1:0]                  held_count;
    logic [mte_pkg::COPY_W-1:0]  copy_left;
    logic [mte_pkg::IDPOS_W-1:0] id_pos;
    logic [1:0]                  size_code;
    logic                        last_cell;
    bit                          mark_pending;
    int unsigned                 mismatches;
    int unsigned                 words_checked;
    int unsigned                 mark_words;
    int unsigned                 tracks_done;

    function new();
      mismatches    = 0;
      words_checked = 0;
      mark_words    = 0;
      tracks_done   = 0;
      clear_state();
    endfunction

    function void clear_state();
      held_bytes[0] = '0;
      held_bytes[1] = '0;
      held_count    = '0;
      copy_left     = '0;
      id_pos        = '0;
      size_code     = '0;
      last_cell     = 1'b0;
      mark_pending  = 1'b0;
    endfunction

    // Clock cell set only when the previous cell and the data bit are both 0
    function void encode_plain(logic [7:0] b);
      logic [15:0] w;
      logic        clk_cell;
      w = '0;
      for (int i = 7; i >= 0; i--) begin
        clk_cell  = ~last_cell & ~b[i];
        w         = {w[13:0], clk_cell, b[i]};
        last_cell = b[i];
      end
      item_words.push_back('{cells: w, run_end: 1'b0, track_end: 1'b0});
    endfunction

    function void put_mark_burst(logic [15:0] w);
      repeat (3) item_words.push_back('{cells: w, run_end: 1'b0, track_end: 1'b0});
      mark_words += 3;
      last_cell   = w[0];
    endfunction

    // Returns the number of bytes taken from the window
    function int scan_window(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      if (a == mte_pkg::INDEX_BYTE && b == mte_pkg::INDEX_BYTE &&
          c == mte_pkg::INDEX_BYTE) begin
        put_mark_burst(mte_pkg::INDEX_WORD);
        return 3;
      end
      if (a == mte_pkg::SYNC_BYTE && b == mte_pkg::SYNC_BYTE &&
          c == mte_pkg::SYNC_BYTE) begin
        put_mark_burst(mte_pkg::SYNC_WORD);
        mark_pending = 1'b1;
        return 3;
      end
      encode_plain(a);
      return 1;
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      logic [7:0]  flush_bytes[3];
      logic [7:0]  a1;
      logic [7:0]  a2;
      int unsigned flush_count;
      int unsigned pos;
      cell_word_t  tail;
      item_words.delete();
      if (copy_left != 0) begin
        encode_plain(b);
        if (id_pos == mte_pkg::ID_SIZE_POS) size_code = b[1:0];
        if (id_pos != 0) id_pos = (id_pos == mte_pkg::ID_LAST_POS) ? '0 : id_pos + 1'b1;
        copy_left = copy_left - 1'b1;
      end else if (mark_pending) begin
        mark_pending = 1'b0;
        if (b == mte_pkg::ID_MARK) begin
          encode_plain(b);
          copy_left = mte_pkg::COPY_W'(mte_pkg::ID_LENGTH - 1);
          id_pos    = mte_pkg::IDPOS_W'(1);
        end else if (b == mte_pkg::DATA_MARK) begin
          encode_plain(b);
          copy_left = mte_pkg::COPY_W'((mte_pkg::BASE_SECTOR << size_code) + 2);
          id_pos    = '0;
        end else begin
          held_bytes[0] = b;
          held_count    = 2'd1;
        end
      end else if (held_count >= 2) begin
        if (scan_window(held_bytes[0], held_bytes[1], b) == 3) begin
          held_count = '0;
        end else begin
          held_bytes[0] = held_bytes[1];
          held_bytes[1] = b;
        end
      end else begin
        held_bytes[held_count[0]] = b;
        held_count = held_count + 2'd1;
      end

      // Flush the held bytes as if zeros followed, then start the track afresh
      if (eot) begin
        if (copy_left == 0 && !mark_pending) begin
          flush_count    = (held_count > 2) ? 2 : held_count;
          flush_bytes[0] = (flush_count > 0) ? held_bytes[0] : 8'h00;
          flush_bytes[1] = (flush_count > 1) ? held_bytes[1] : 8'h00;
          flush_bytes[2] = 8'h00;
          pos = 0;
          while (pos < flush_count) begin
            a1 = (pos + 1 < flush_count) ? flush_bytes[pos+1] : 8'h00;
            a2 = (pos + 2 < flush_count) ? flush_bytes[pos+2] : 8'h00;
            pos += scan_window(flush_bytes[pos], a1, a2);
          end
        end
        clear_state();
        tracks_done++;
      end

      if (item_words.size() > 0) begin
        tail           = item_words.pop_back();
        tail.run_end   = 1'b1;
        tail.track_end = eot;
        item_words.push_back(tail);
      end
      foreach (item_words[k]) expected_words.push_back(item_words[k]);
    endfunction

    function void check_word(cell_word_t got);
      cell_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: word %h (run_end %b track_end %b) arrived, none expected",
                   $time, got.cells, got.run_end, got.track_end);
        return;
      end
      want = expected_words.pop_front();
      if (want.cells !== got.cells || want.run_end !== got.run_end ||
          want.track_end !== got.track_end) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: expected cells %h run_end %b track_end %b, got %h %b %b",
                   $time, want.cells, want.run_end, want.track_end,
                   got.cells, got.run_end, got.track_end);
      end
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
// Testbench top: drives track bytes into the MFM track encoder and checks every word.
module tb;

  localparam int unsigned RANDOM_ITEMS = 180;
  localparam int unsigned QUIET_ITEMS  = 20;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic clk_i;
  logic rst_ni;

  mte_in_if  byte_if ();
  mte_out_if word_if ();

  mfm_track_encoder_with_marks u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (word_if)
  );

  mte_tb_pkg::mfm_word_scoreboard track_sb;
  bit                             idling;
  bit                             long_hold;
  int unsigned                    bytes_sent;
  int unsigned                    idle_cycles = 0;
  mte_tb_pkg::cell_word_t         seen_word;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Word receiver: random stall bursts, plus one long hold-off on request
  initial begin
    word_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        word_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold = 1'b0;
        word_if.ready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        word_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        word_if.ready <= 1'b1;
      end else begin
        word_if.ready <= 1'b1;
      end
    end
  end

  // Sample both channels at the rising edge; watchdog on idle handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready)
        track_sb.note_byte(byte_if.track_byte, byte_if.end_of_track);
      if (word_if.valid && word_if.ready) begin
        seen_word.cells     = word_if.cell_word;
        seen_word.run_end   = word_if.run_end;
        seen_word.track_end = word_if.track_end;
        track_sb.check_word(seen_word);
      end
      if ((byte_if.valid && byte_if.ready) || (word_if.valid && word_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Bias towards mark bytes so that near misses and marks inside copies occur
  function automatic logic [7:0] pick_track_byte();
    case ($urandom_range(0, 8))
      0:       return mte_pkg::INDEX_BYTE;
      1:       return mte_pkg::SYNC_BYTE;
      2:       return mte_pkg::ID_MARK;
      3:       return mte_pkg::DATA_MARK;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (idling && $urandom_range(0, 5) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    byte_if.valid        <= 1'b1;
    byte_if.track_byte   <= b;
    byte_if.end_of_track <= eot;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_mark(input logic [7:0] mark);
    repeat (3) send_byte(mte_pkg::SYNC_BYTE, 1'b0);
    send_byte(mark, 1'b0);
  endtask

  task automatic send_id(input bit small_sector);
    logic [7:0] size_byte;
    size_byte = 8'($urandom);
    if (small_sector) size_byte[1:0] = 2'd0;
    send_mark(mte_pkg::ID_MARK);
    repeat (3) send_byte(pick_track_byte(), 1'b0);
    send_byte(size_byte, 1'b0);
    repeat (2) send_byte(pick_track_byte(), 1'b0);
  endtask

  // A full copy assumes the smallest sector; otherwise end the track inside the copy
  task automatic send_data(input bit full_copy);
    int unsigned n;
    send_mark(mte_pkg::DATA_MARK);
    if (full_copy) begin
      repeat (mte_pkg::BASE_SECTOR + 2) send_byte(pick_track_byte(), 1'b0);
    end else begin
      n = $urandom_range(1, 10);
      repeat (n - 1) send_byte(pick_track_byte(), 1'b0);
      send_byte(pick_track_byte(), 1'b1);
    end
  endtask

  initial begin
    int unsigned random_stop;
    rst_ni               = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.track_byte   = '0;
    byte_if.end_of_track = 1'b0;
    idling               = 1'b1;
    long_hold            = 1'b0;
    bytes_sent           = 0;
    track_sb             = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Plain bytes, index burst, sync with plain follower, ID with largest size,
    // then a data copy cut short by the end of the track
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (3) send_byte(mte_pkg::INDEX_BYTE, 1'b0);
    send_mark(8'h00);
    send_mark(mte_pkg::ID_MARK);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_mark(mte_pkg::DATA_MARK);
    send_byte(8'h5A, 1'b1);
    // Track end with two held sync bytes, with an index burst on the last byte,
    // and a track of one byte
    send_byte(mte_pkg::SYNC_BYTE, 1'b0);
    send_byte(mte_pkg::SYNC_BYTE, 1'b1);
    repeat (2) send_byte(mte_pkg::INDEX_BYTE, 1'b0);
    send_byte(mte_pkg::INDEX_BYTE, 1'b1);
    send_byte(8'hFF, 1'b1);

    random_stop = bytes_sent + RANDOM_ITEMS;
    // Whole sector while the receiver holds off, so the input backs up
    long_hold = 1'b1;
    send_id(1'b1);
    send_data(1'b1);

    while (bytes_sent < random_stop) begin
      if (bytes_sent + QUIET_ITEMS >= random_stop) idling = 1'b0;
      case ($urandom_range(0, 9))
        0, 1:    repeat ($urandom_range(1, 8)) send_byte(pick_track_byte(), 1'b0);
        2:       repeat (3) send_byte(mte_pkg::INDEX_BYTE, 1'b0);
        3, 4:    send_id(1'b0);
        5, 6:    send_data(1'b0);
        7: begin
          repeat ($urandom_range(1, 3)) send_byte(mte_pkg::SYNC_BYTE, 1'b0);
          send_byte(pick_track_byte(), 1'b0);
        end
        default: send_byte(pick_track_byte(), 1'b1);
      endcase
    end
    send_byte(pick_track_byte(), 1'b1);
    byte_if.valid <= 1'b0;

    while (track_sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d tracks and %0d track bytes, including one full sector copy;",
             track_sb.tracks_done, bytes_sent);
    $display("%0d words checked, %0d of them index or sync marks.",
             track_sb.words_checked, track_sb.mark_words);
    if (track_sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
